// File: rtl/tbbeq_pkg.sv
// Shared types and constants for the three-band biquad equalizer.
// Depends on nothing; the band cell and the top level import it.

package tbbeq_pkg;

   // Stream and configuration widths.
   localparam int SAMPLE_WIDTH    = 16;
   localparam int SAMPLE_FRAC     = 15;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int BAND_SEL_W      = CSR_INDEX_WIDTH - 1;
   localparam int NUM_BANDS       = 3;

   // Register kind, taken from the low bit of the register index.
   localparam logic REG_KIND_FF = 1'b0;
   localparam logic REG_KIND_FB = 1'b1;

   // Coefficient layout: three Q3.18 feedforward fields, two Q2.30 feedback fields.
   localparam int FF_FIELD     = 21;
   localparam int FF_FRAC      = 18;
   localparam int FB_FIELD     = 32;
   localparam int FB_FRAC      = 30;
   localparam int FF_REG_WIDTH = 3 * FF_FIELD;
   localparam logic [FF_REG_WIDTH-1:0] FF_RESET = FF_REG_WIDTH'(262144);

   // Internal state format keeps this many integer bits, sign included.
   localparam int STATE_INT_BITS = 8;

   // Multiplier: a 32-bit coefficient times a 33-bit slice of the state value.
   localparam int COEF_WIDTH = 32;
   localparam int MUL_SPLIT  = 32;

   // Guard bits of the accumulator above the state width.
   localparam int ACC_GUARD = 5;

   // Five taps, each taken as a low and a high partial product.
   localparam int TAP_STEPS = 10;

   // Write strobe and data for one band's coefficient registers.
   typedef struct packed {
      logic                      wr_ff;
      logic                      wr_fb;
      logic [CSR_DATA_WIDTH-1:0] data;
   } band_wr_type;

endpackage

// File: rtl/three_band_biquad_equalizer.sv
// Top level of the three-band biquad equalizer: bass, mid and treble cells in a row.
// Depends on tbbeq_pkg and tbbeq_band_cell.
//
//   port group  direction  payload
//   req_*       in         tdata[15:0] sample_in, tlast block_end_in
//   rsp_*       out        tdata[15:0] sample_out, tlast block_end_out
//   csr_*       in         index 0..5 selects a coefficient register, wdata up to 64 bits
//
// Each band cell takes a word, makes ten passes through its 32x33 multiplier (a low
// and a high partial product for each of five taps), then adds, saturates and updates
// history, and hands the result over. The three cells run at the same time, so the bass
// cell can take a new word while the mid and treble cells still work on earlier ones.
// Reset sets every band to a unity pass with cleared history; there is no clearing pass.
// With rsp_tready low the result holds, the treble cell waits, and the chain backs up.

module three_band_biquad_equalizer #(
   parameter int STATE_WIDTH = 40
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [15:0]                            req_tdata,  // [15:0] sample_in
   input  logic                                   req_tlast,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [15:0]                            rsp_tdata,  // [15:0] sample_out
   output logic                                   rsp_tlast,
   input  logic                                   csr_we,
   input  logic [tbbeq_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [tbbeq_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import tbbeq_pkg::*;

   localparam int SHIFT = STATE_WIDTH - STATE_INT_BITS - SAMPLE_FRAC;
   localparam int Q_W   = STATE_WIDTH - SHIFT;

   band_wr_type                   band_wr    [NUM_BANDS];
   logic                          link_valid [NUM_BANDS+1];
   logic                          link_ready [NUM_BANDS+1];
   logic signed [STATE_WIDTH-1:0] link_x     [NUM_BANDS+1];
   logic                          link_last  [NUM_BANDS+1];

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0]       rsp_sample_ff, rsp_sample_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic signed [STATE_WIDTH-1:0] y_out;
   logic signed [Q_W-1:0]         q_trunc;
   logic [Q_W-SAMPLE_WIDTH:0]     q_top;
   logic [SAMPLE_WIDTH-1:0]       sample_sat;

   // Scale the Q1.15 input word into the state format.
   assign link_valid[0] = req_tvalid;
   assign link_x[0]     = {{(STATE_INT_BITS - 1){req_tdata[SAMPLE_WIDTH-1]}},
                           req_tdata[SAMPLE_WIDTH-1:0], {SHIFT{1'b0}}};
   assign link_last[0]  = req_tlast;
   assign req_tready    = link_ready[0];

   // One cell per band; the index's upper bits pick the band, the low bit the register.
   for (genvar b = 0; b < NUM_BANDS; b++) begin : g_band
      assign band_wr[b].wr_ff = csr_we && (csr_index[CSR_INDEX_WIDTH-1:1] == BAND_SEL_W'(b))
                                && (csr_index[0] == REG_KIND_FF);
      assign band_wr[b].wr_fb = csr_we && (csr_index[CSR_INDEX_WIDTH-1:1] == BAND_SEL_W'(b))
                                && (csr_index[0] == REG_KIND_FB);
      assign band_wr[b].data  = csr_wdata;

      tbbeq_band_cell #(
         .STATE_WIDTH (STATE_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .wr        (band_wr[b]),
         .in_valid  (link_valid[b]),
         .in_ready  (link_ready[b]),
         .in_x      (link_x[b]),
         .in_last   (link_last[b]),
         .out_valid (link_valid[b+1]),
         .out_ready (link_ready[b+1]),
         .out_y     (link_x[b+1]),
         .out_last  (link_last[b+1])
      );
   end

   // The output register takes a word when empty or being emptied.
   assign link_ready[NUM_BANDS] = !rsp_valid_ff || rsp_tready;

   // Back to 16 bits: truncate toward zero, then saturate.
   assign y_out   = link_x[NUM_BANDS];
   assign q_trunc = y_out[STATE_WIDTH-1:SHIFT]
                    + Q_W'(y_out[STATE_WIDTH-1] && (|y_out[SHIFT-1:0]));
   assign q_top   = q_trunc[Q_W-1:SAMPLE_WIDTH-1];

   always_comb begin
      if ((&q_top) || (~|q_top)) begin
         sample_sat = q_trunc[SAMPLE_WIDTH-1:0];
      end else if (q_trunc[Q_W-1]) begin
         sample_sat = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
      end else begin
         sample_sat = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
      end
   end

   // Output register next values.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      if (link_valid[NUM_BANDS] && link_ready[NUM_BANDS]) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = sample_sat;
         rsp_last_in   = link_last[NUM_BANDS];
      end else if (rsp_tready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sample_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // The bass cell is busy for the whole word once it takes one.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("bass cell took a second word while busy");

   // A word leaving the treble cell lands in the output register with its flag.
   a_handoff_lands: assert property (@(posedge clock) disable iff (reset)
      (link_valid[NUM_BANDS] && link_ready[NUM_BANDS])
      |=> (rsp_tvalid && (rsp_tlast == $past(link_last[NUM_BANDS]))))
      else $error("treble result did not reach the output register");
`endif

endmodule

// File: rtl/tbbeq_band_cell.sv
// One biquad band of the equalizer chain: coefficients, history and a shared MAC.
// Depends on tbbeq_pkg.

module tbbeq_band_cell #(
   parameter int STATE_WIDTH = 40
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tbbeq_pkg::band_wr_type        wr,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [STATE_WIDTH-1:0] in_x,
   input  logic                          in_last,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [STATE_WIDTH-1:0] out_y,
   output logic                          out_last
);
   import tbbeq_pkg::*;

   localparam int ACC_W  = STATE_WIDTH + ACC_GUARD;
   localparam int OP_W   = MUL_SPLIT + 1;
   localparam int PROD_W = COEF_WIDTH + OP_W;
   localparam int EXT_W  = 2 * MUL_SPLIT + 1;
   localparam int STEP_W = $clog2(TAP_STEPS);
   localparam int TAP_W  = STEP_W - 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MAC  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam logic [TAP_W-1:0] TAP_B0 = TAP_W'(0);
   localparam logic [TAP_W-1:0] TAP_B1 = TAP_W'(1);
   localparam logic [TAP_W-1:0] TAP_B2 = TAP_W'(2);
   localparam logic [TAP_W-1:0] TAP_A1 = TAP_W'(3);
   localparam logic [TAP_W-1:0] TAP_A2 = TAP_W'(4);

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(TAP_STEPS - 1);

   function automatic logic signed [COEF_WIDTH-1:0] widen_b(input logic [FF_FIELD-1:0] f);
      return {{(COEF_WIDTH - FF_FIELD){f[FF_FIELD-1]}}, f};
   endfunction

   logic [1:0]                    state_ff, state_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic [FF_REG_WIDTH-1:0]       ff_ff, ff_in;
   logic [CSR_DATA_WIDTH-1:0]     fb_ff, fb_in;
   logic signed [STATE_WIDTH-1:0] x1_ff, x1_in, x2_ff, x2_in;
   logic signed [STATE_WIDTH-1:0] y1_ff, y1_in, y2_ff, y2_in;
   logic signed [STATE_WIDTH-1:0] x_ff, x_in, y_ff, y_in;
   logic                          last_ff, last_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic                          tag_half_ff, tag_half_in;
   logic                          tag_fb_ff, tag_fb_in;

   logic [TAP_W-1:0]              tap;
   logic                          half;
   logic                          fb_sel;
   logic signed [STATE_WIDTH-1:0] opnd_val;
   logic signed [COEF_WIDTH-1:0]  coef;
   logic [EXT_W-1:0]              v_ext;
   logic signed [OP_W-1:0]        opnd;
   logic signed [PROD_W-1:0]      term_wide;
   logic signed [ACC_W-1:0]       sum;
   logic [ACC_W-STATE_WIDTH:0]    sum_top;
   logic signed [STATE_WIDTH-1:0] y_sat;

   // Pick the tap for this step: value and coefficient.
   always_comb begin
      tap  = step_ff[STEP_W-1:1];
      half = step_ff[0];
      case (tap)
         TAP_B0: begin
            opnd_val = x_ff;
            coef     = widen_b(ff_ff[FF_FIELD-1:0]);
            fb_sel   = 1'b0;
         end
         TAP_B1: begin
            opnd_val = x1_ff;
            coef     = widen_b(ff_ff[2*FF_FIELD-1:FF_FIELD]);
            fb_sel   = 1'b0;
         end
         TAP_B2: begin
            opnd_val = x2_ff;
            coef     = widen_b(ff_ff[3*FF_FIELD-1:2*FF_FIELD]);
            fb_sel   = 1'b0;
         end
         TAP_A1: begin
            opnd_val = y1_ff;
            coef     = fb_ff[FB_FIELD-1:0];
            fb_sel   = 1'b1;
         end
         TAP_A2: begin
            opnd_val = y2_ff;
            coef     = fb_ff[2*FB_FIELD-1:FB_FIELD];
            fb_sel   = 1'b1;
         end
         default: begin
            opnd_val = x_ff;
            coef     = '0;
            fb_sel   = 1'b0;
         end
      endcase
   end

   // Split the value: zero-extended low 32 bits first, then the signed upper part.
   assign v_ext   = {{(EXT_W - STATE_WIDTH){opnd_val[STATE_WIDTH-1]}}, opnd_val};
   assign opnd    = half ? v_ext[EXT_W-1:MUL_SPLIT] : {1'b0, v_ext[MUL_SPLIT-1:0]};
   assign prod_in = coef * opnd;

   // The low partial is floored to the state fraction; the high partial is exact.
   always_comb begin
      case ({tag_half_ff, tag_fb_ff})
         2'b00:   term_wide = prod_ff >>> FF_FRAC;
         2'b01:   term_wide = prod_ff >>> FB_FRAC;
         2'b10:   term_wide = prod_ff <<< (MUL_SPLIT - FF_FRAC);
         2'b11:   term_wide = prod_ff <<< (MUL_SPLIT - FB_FRAC);
         default: term_wide = '0;
      endcase
   end

   assign sum     = acc_ff + term_wide[ACC_W-1:0];
   assign sum_top = sum[ACC_W-1:STATE_WIDTH-1];

   // Saturate the band output to the state range.
   always_comb begin
      if ((&sum_top) || (~|sum_top)) begin
         y_sat = sum[STATE_WIDTH-1:0];
      end else if (sum[ACC_W-1]) begin
         y_sat = {1'b1, {(STATE_WIDTH - 1){1'b0}}};
      end else begin
         y_sat = {1'b0, {(STATE_WIDTH - 1){1'b1}}};
      end
   end

   // Sequencer: take a word, run ten multiplier passes, finish, hand over.
   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      ff_in       = ff_ff;
      fb_in       = fb_ff;
      x1_in       = x1_ff;
      x2_in       = x2_ff;
      y1_in       = y1_ff;
      y2_in       = y2_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      last_in     = last_ff;
      acc_in      = acc_ff;
      tag_half_in = half;
      tag_fb_in   = fb_sel;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               x_in     = in_x;
               last_in  = in_last;
               acc_in   = '0;
               step_in  = '0;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (step_ff != '0) begin
               acc_in = sum;
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            y_in     = y_sat;
            x2_in    = x1_ff;
            x1_in    = x_ff;
            y2_in    = y1_ff;
            y1_in    = y_sat;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A coefficient write restarts the band from silence.
      if (wr.wr_ff) begin
         ff_in = wr.data[FF_REG_WIDTH-1:0];
      end
      if (wr.wr_fb) begin
         fb_in = wr.data;
      end
      if (wr.wr_ff || wr.wr_fb) begin
         x1_in = '0;
         x2_in = '0;
         y1_in = '0;
         y2_in = '0;
      end
   end

   // Control, coefficients and history.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         ff_ff    <= FF_RESET;
         fb_ff    <= '0;
         x1_ff    <= '0;
         x2_ff    <= '0;
         y1_ff    <= '0;
         y2_ff    <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         ff_ff    <= ff_in;
         fb_ff    <= fb_in;
         x1_ff    <= x1_in;
         x2_ff    <= x2_in;
         y1_ff    <= y1_in;
         y2_ff    <= y2_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      last_ff     <= last_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      tag_half_ff <= tag_half_in;
      tag_fb_ff   <= tag_fb_in;
   end

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_DONE);
   assign out_y     = y_ff;
   assign out_last  = last_ff;

endmodule

// File: tb/three_band_biquad_equalizer_test.sv
// Self-checking testbench for the three-band biquad equalizer.
// Depends on tbbeq_pkg and the three_band_biquad_equalizer top level.
// A directed table runs first, then random phases with random coefficient settings.

`timescale 1ns / 1ps

module three_band_biquad_equalizer_test;
   import tbbeq_pkg::*;

   localparam int STATE_WIDTH   = 40;
   localparam int STATE_FRAC    = STATE_WIDTH - STATE_INT_BITS;
   localparam int SCALE_SHIFT   = STATE_FRAC - SAMPLE_FRAC;
   localparam int WIDE          = 96;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 40;
   localparam int NUM_PHASES    = 8;
   localparam int PHASE_WORDS   = 75;
   localparam int PLAN_ROWS     = 30;
   localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
   localparam longint UNITY_FF   = longint'(1) << FF_FRAC;

   // History slots of one band.
   localparam int HIST_X1 = 0;
   localparam int HIST_X2 = 1;
   localparam int HIST_Y1 = 2;
   localparam int HIST_Y2 = 3;

   typedef logic signed [STATE_WIDTH-1:0] state_type;
   typedef logic signed [WIDE-1:0]        wide_type;

   localparam wide_type STATE_MAX = (wide_type'(1) <<< (STATE_WIDTH - 1)) - 1;
   localparam wide_type STATE_MIN = -STATE_MAX - 1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_BASS_FF, REG_BASS_FB, REG_MID_FF, REG_MID_FB,
      REG_TREBLE_FF, REG_TREBLE_FB, REG_SPARE_LO, REG_SPARE_HI
   } reg_index_type;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      reg_index_type             index;
      logic [CSR_DATA_WIDTH-1:0] value;
      logic [SAMPLE_WIDTH-1:0]   sample;
      logic                      block_end;
      logic                      typed;
      logic [SAMPLE_WIDTH-1:0]   want;
   } plan_row_type;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] sample;
      logic                    block_end;
   } eq_word_type;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_tvalid  = 1'b0;
   logic                       req_tready;
   logic [15:0]                req_tdata   = '0;  // [15:0] sample_in
   logic                       req_tlast   = 1'b0;
   logic                       rsp_tvalid;
   logic                       rsp_tready  = 1'b0;
   logic [15:0]                rsp_tdata;         // [15:0] sample_out
   logic                       rsp_tlast;
   logic                       csr_we      = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index   = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata   = '0;

   // Set during a phase in which neither side idles.
   logic quiet = 1'b0;

   int mismatches    = 0;
   int words_sent    = 0;
   int words_checked = 0;
   int csr_writes    = 0;
   int cycle_count   = 0;

   // Predictor copy of the coefficient registers and band histories.
   logic [FF_REG_WIDTH-1:0]   model_ff [NUM_BANDS];
   logic [CSR_DATA_WIDTH-1:0] model_fb [NUM_BANDS];
   state_type                 band_hist [NUM_BANDS][4];

   // Equalized words still owed by the block, oldest first.
   eq_word_type awaited_words [$];

   // Directed stimulus: unity pass after reset, gain extremes, ignored indexes,
   // state saturation through strong feedback, and history clearing on a write.
   plan_row_type opening_plan [PLAN_ROWS] = '{
      '{ROW_WORD, REG_BASS_FF, 64'h0, 16'h0000, 1'b0, 1'b1, 16'h0000},
      '{ROW_WORD, REG_BASS_FF, 64'h0, 16'h7FFF, 1'b0, 1'b1, 16'h7FFF},
      '{ROW_WORD, REG_BASS_FF, 64'h0, 16'h8000, 1'b1, 1'b1, 16'h8000},
      '{ROW_WORD, REG_BASS_FF, 64'h0, 16'h0001, 1'b0, 1'b1, 16'h0001},
      '{ROW_WORD, REG_BASS_FF, 64'h0, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF},
      '{ROW_CSR,  REG_BASS_FF, 64'h8000_0000_000F_FFFF, 16'h0, 1'b0, 1'b0, 16'h0},
      '{ROW_WORD, REG_BASS_FF, 64'h0, 16'h7FFF, 1'b0, 1'b1, 16'h7FFF},
      '{ROW_WORD, REG_BASS_FF, 64'h0, 16'h8000, 1'b0, 1'b1, 16'h8000},
      '{ROW_CSR,  REG_BASS_FF, 64'h0000_0000_0010_0000, 16'h0, 1'b0, 1'b0, 16'h0},
      '{ROW_WORD, REG_BASS_FF, 64'h0, 16'h8000, 1'b0, 1'b1, 16'h7FFF},
      '{ROW_WORD, REG_BASS_FF, 64'h0, 16'h7FFF, 1'b0, 1'b1, 16'h8000},
      '{ROW_CSR,  REG_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 1'b0, 1'b0, 16'h0},
      '{ROW_CSR,  REG_SPARE_HI, 64'h0, 16'h0, 1'b0, 1'b0, 16'h0},
      '{ROW_WORD, REG_BASS_FF, 64'h0, 16'h0001, 1'b1, 1'b1, 16'hFFFC},
      '{ROW_CSR,  REG_BASS_FF, 64'h0000_0000_0004_0000, 16'h0, 1'b0, 1'b0, 16'h0},
      '{ROW_CSR,  REG_MID_FF, {1'b0, 21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF},
        16'h0, 1'b0, 1'b0, 16'h0},
      '{ROW_CSR,  REG_MID_FB, {32'h0, 32'h7FFF_FFFF}, 16'h0, 1'b0, 1'b0, 16'h0},
      '{ROW_WORD, REG_BASS_FF, 64'h0, 16'h7FFF, 1'b0, 1'b0, 16'h0},
      '{ROW_WORD, REG_BASS_FF, 64'h0, 16'h7FFF, 1'b0, 1'b0, 16'h0},
      '{ROW_WORD, REG_BASS_FF, 64'h0, 16'h7FFF, 1'b0, 1'b0, 16'h0},
      '{ROW_WORD, REG_BASS_FF, 64'h0, 16'h8000, 1'b1, 1'b0, 16'h0},
      '{ROW_CSR,  REG_TREBLE_FF, {1'b0, 21'h100000, 21'h100000, 21'h100000},
        16'h0, 1'b0, 1'b0, 16'h0},
      '{ROW_CSR,  REG_TREBLE_FB, {32'h8000_0000, 32'h8000_0000}, 16'h0, 1'b0, 1'b0, 16'h0},
      '{ROW_CSR,  REG_BASS_FB, {32'hC000_0000, 32'h2000_0000}, 16'h0, 1'b0, 1'b0, 16'h0},
      '{ROW_WORD, REG_BASS_FF, 64'h0, 16'h4000, 1'b0, 1'b0, 16'h0},
      '{ROW_WORD, REG_BASS_FF, 64'h0, 16'hC000, 1'b0, 1'b0, 16'h0},
      '{ROW_WORD, REG_BASS_FF, 64'h0, 16'h0123, 1'b1, 1'b0, 16'h0},
      '{ROW_CSR,  REG_MID_FF, 64'h0000_0000_0004_0000, 16'h0, 1'b0, 1'b0, 16'h0},
      '{ROW_WORD, REG_BASS_FF, 64'h0, 16'h7FFF, 1'b0, 1'b0, 16'h0},
      '{ROW_WORD, REG_BASS_FF, 64'h0, 16'h8000, 1'b1, 1'b0, 16'h0}
   };

   three_band_biquad_equalizer #(
      .STATE_WIDTH(STATE_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Exact product of a coefficient and a state value, floored to state precision.
   function automatic wide_type scaled_product(wide_type coef, state_type v, int shift);
      wide_type vw;
      vw = v;
      return (coef * vw) >>> shift;
   endfunction

   // One direct-form-1 section; updates that band's history.
   function automatic state_type filter_band(int band, state_type x);
      wide_type b0, b1, b2, a1, a2, acc;
      state_type y;
      b0 = $signed(model_ff[band][FF_FIELD-1:0]);
      b1 = $signed(model_ff[band][2*FF_FIELD-1:FF_FIELD]);
      b2 = $signed(model_ff[band][3*FF_FIELD-1:2*FF_FIELD]);
      a1 = $signed(model_fb[band][FB_FIELD-1:0]);
      a2 = $signed(model_fb[band][2*FB_FIELD-1:FB_FIELD]);
      acc = scaled_product(b0, x, FF_FRAC)
          + scaled_product(b1, band_hist[band][HIST_X1], FF_FRAC)
          + scaled_product(b2, band_hist[band][HIST_X2], FF_FRAC)
          + scaled_product(a1, band_hist[band][HIST_Y1], FB_FRAC)
          + scaled_product(a2, band_hist[band][HIST_Y2], FB_FRAC);
      if (acc > STATE_MAX) begin
         y = STATE_MAX[STATE_WIDTH-1:0];
      end else if (acc < STATE_MIN) begin
         y = STATE_MIN[STATE_WIDTH-1:0];
      end else begin
         y = acc[STATE_WIDTH-1:0];
      end
      band_hist[band][HIST_X2] = band_hist[band][HIST_X1];
      band_hist[band][HIST_X1] = x;
      band_hist[band][HIST_Y2] = band_hist[band][HIST_Y1];
      band_hist[band][HIST_Y1] = y;
      return y;
   endfunction

   // Full cascade: scale up, bass, mid, treble, then truncate and clip to 16 bits.
   function automatic logic [SAMPLE_WIDTH-1:0] equalize(logic [SAMPLE_WIDTH-1:0] sample);
      state_type x;
      longint q;
      x = $signed(sample);
      x = x <<< SCALE_SHIFT;
      for (int band = 0; band < NUM_BANDS; band++) begin
         x = filter_band(band, x);
      end
      q = x;
      q = q / (longint'(1) << SCALE_SHIFT);
      if (q > SAMPLE_MAX) begin
         q = SAMPLE_MAX;
      end else if (q < SAMPLE_MIN) begin
         q = SAMPLE_MIN;
      end
      return q[SAMPLE_WIDTH-1:0];
   endfunction

   // Random coefficient word: raw bits, a mild stable filter, extremes, or unity.
   function automatic logic [CSR_DATA_WIDTH-1:0] draw_coef(logic kind);
      logic [CSR_DATA_WIDTH-1:0] word, mask;
      longint field_val, top, bot;
      int style, width, fields;
      style = $urandom_range(0, 3);
      word = {$urandom, $urandom};
      width = (kind == REG_KIND_FF) ? FF_FIELD : FB_FIELD;
      fields = (kind == REG_KIND_FF) ? 3 : 2;
      top = (longint'(1) << (width - 1)) - 1;
      bot = -top - 1;
      field_val = 0;
      if (style != 0) begin
         for (int k = 0; k < fields; k++) begin
            case (style)
               1: begin
                  if (kind == REG_KIND_FB) begin
                     field_val = longint'($urandom_range(0, 1 << 29)) - (1 << 28);
                  end else if (k == 0) begin
                     field_val = UNITY_FF + longint'($urandom_range(0, 8192)) - 4096;
                  end else begin
                     field_val = longint'($urandom_range(0, 65535)) - 32768;
                  end
               end
               2: begin
                  case ($urandom_range(0, 2))
                     0: field_val = top;
                     1: field_val = bot;
                     default: field_val = 0;
                  endcase
               end
               default: begin
                  field_val = (kind == REG_KIND_FF && k == 0) ? UNITY_FF : 0;
               end
            endcase
            mask = ((64'd1 << width) - 1) << (k * width);
            word = (word & ~mask) | ((64'(field_val) << (k * width)) & mask);
         end
      end
      return word;
   endfunction

   // Register write, mirrored into the predictor. A band write clears its history.
   task automatic write_csr(reg_index_type index, logic [CSR_DATA_WIDTH-1:0] value);
      int band;
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      csr_writes++;
      if (index <= REG_TREBLE_FB) begin
         band = int'(index) >> 1;
         if (index[0] == REG_KIND_FF) begin
            model_ff[band] = value[FF_REG_WIDTH-1:0];
         end else begin
            model_fb[band] = value;
         end
         for (int k = 0; k < 4; k++) begin
            band_hist[band][k] = '0;
         end
      end
   endtask

   // Offer one word after a random gap and hold it until the block takes it.
   task automatic send_word(logic [SAMPLE_WIDTH-1:0] sample, logic block_end,
                            logic typed, logic [SAMPLE_WIDTH-1:0] want);
      eq_word_type w;
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 10);
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      req_tlast  <= block_end;
      do @(posedge clock); while (!req_tready);
      w.sample    = equalize(sample);
      w.block_end = block_end;
      if (typed) begin
         w.sample = want;
      end
      awaited_words.push_back(w);
      words_sent++;
   endtask

   // Stop sending and wait until every owed word has come back and the block is idle.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Stimulus and final verdict.
   initial begin
      logic [SAMPLE_WIDTH-1:0] sample;
      for (int b = 0; b < NUM_BANDS; b++) begin
         model_ff[b] = FF_RESET;
         model_fb[b] = '0;
         for (int k = 0; k < 4; k++) begin
            band_hist[b][k] = '0;
         end
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (opening_plan[r]) begin
         if (opening_plan[r].kind == ROW_CSR) begin
            drain_results();
            write_csr(opening_plan[r].index, opening_plan[r].value);
         end else begin
            send_word(opening_plan[r].sample, opening_plan[r].block_end,
                      opening_plan[r].typed, opening_plan[r].want);
         end
      end

      // Random phases, each under a fresh coefficient setting.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         drain_results();
         quiet = (phase == 3);
         for (int r = 0; r <= int'(REG_TREBLE_FB); r++) begin
            if (phase == 0 || $urandom_range(0, 1) == 1) begin
               write_csr(reg_index_type'(r),
                         draw_coef((r % 2 == 1) ? REG_KIND_FB : REG_KIND_FF));
            end
         end
         if ($urandom_range(0, 3) == 0) begin
            write_csr($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, {$urandom, $urandom});
         end
         for (int n = 0; n < PHASE_WORDS; n++) begin
            case ($urandom_range(0, 9))
               0: begin
                  case ($urandom_range(0, 3))
                     0: sample = 16'h7FFF;
                     1: sample = 16'h8000;
                     2: sample = 16'h0000;
                     default: sample = 16'hFFFF;
                  endcase
               end
               1, 2: sample = 16'($urandom_range(0, 512)) - 16'd256;
               default: sample = 16'($urandom);
            endcase
            send_word(sample, ($urandom_range(0, 7) == 0), 1'b0, '0);
            if ($urandom_range(0, 63) == 0) begin
               drain_results();
            end
         end
      end
      quiet = 1'b0;
      drain_results();

      $display("Equalizer run: %0d samples over %0d coefficient phases, %0d results checked.",
               words_sent, NUM_PHASES, words_checked);
      $display("Register writes: %0d, covering unused indexes, extremes and unstable filters.",
               csr_writes);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Result side: random stall before accepting each word.
   initial begin
      int stall;
      while (reset) @(negedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 10);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Compare each accepted result word with the oldest owed word.
   always @(posedge clock) begin
      eq_word_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_words.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected word, expected none, got sample_out %0d block_end %0b",
                     $time, $signed(rsp_tdata), rsp_tlast);
         end else begin
            w = awaited_words.pop_front();
            words_checked++;
            if (rsp_tdata !== w.sample) begin
               mismatches++;
               $display("%0t: sample_out mismatch, expected %0d, got %0d",
                        $time, $signed(w.sample), $signed(rsp_tdata));
            end
            if (rsp_tlast !== w.block_end) begin
               mismatches++;
               $display("%0t: block_end_out mismatch, expected %0b, got %0b",
                        $time, w.block_end, rsp_tlast);
            end
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d words still owed", $time, awaited_words.size());
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule

// File: three_band_biquad_equalizer.f
rtl/tbbeq_pkg.sv
rtl/tbbeq_band_cell.sv
rtl/three_band_biquad_equalizer.sv
tb/three_band_biquad_equalizer_test.sv
